FILE: rtl/rtu_fg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RTU frame gap receiver package
// Shared event codes, field widths and reset constants.
// ----------------------------------------------------------------------------
package rtu_fg_pkg;

   localparam int BUF_DEPTH_DEF = 64;

   localparam int REQ_TYPE_W = 2;
   localparam int BYTE_W     = 8;
   localparam int INDEX_W    = 6;
   localparam int LEN_W      = 7;
   localparam int GAP_W      = 16;

   localparam logic [GAP_W-1:0] GAP_TICKS_RST = 16'd10;

   // event kinds carried in req_type
   typedef enum logic [REQ_TYPE_W-1:0] {
      EV_BYTE  = 2'd0,
      EV_TICK  = 2'd1,
      EV_CLEAR = 2'd2,
      EV_READ  = 2'd3
   } req_kind_type;

endpackage : rtu_fg_pkg
`default_nettype wire

FILE: rtl/rtu_fg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RTU frame gap receiver channels
// Valid/ready channels for events, results and the gap threshold register.
// ----------------------------------------------------------------------------
interface rtu_fg_req_if;
   logic                               valid;
   logic                               ready;
   logic [rtu_fg_pkg::REQ_TYPE_W-1:0] req_type;
   logic [rtu_fg_pkg::BYTE_W-1:0]     rx_byte;
   logic [rtu_fg_pkg::INDEX_W-1:0]    read_index;

   modport source (output valid, output req_type, output rx_byte, output read_index,
                   input ready);
   modport sink (input valid, input req_type, input rx_byte, input read_index,
                 output ready);
endinterface : rtu_fg_req_if

interface rtu_fg_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           frame_ready;
   logic [rtu_fg_pkg::LEN_W-1:0]  frame_len;
   logic                           receiving;
   logic [rtu_fg_pkg::BYTE_W-1:0] read_data;

   modport source (output valid, output frame_ready, output frame_len,
                   output receiving, output read_data, input ready);
   modport sink (input valid, input frame_ready, input frame_len,
                 input receiving, input read_data, output ready);
endinterface : rtu_fg_rsp_if

interface rtu_fg_csr_if;
   logic                          valid;
   logic                          ready;
   logic [rtu_fg_pkg::GAP_W-1:0] gap_ticks;

   modport source (output valid, output gap_ticks, input ready);
   modport sink (input valid, input gap_ticks, output ready);
endinterface : rtu_fg_csr_if
`default_nettype wire

FILE: rtl/rtu_fg_buf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RTU frame buffer
// Single-port-write, single-read byte memory with registered read data.
// ----------------------------------------------------------------------------
module rtu_fg_buf #(
   parameter int DEPTH = rtu_fg_pkg::BUF_DEPTH_DEF,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                           clock,
   input  wire logic                           wr_en,
   input  wire logic [AW-1:0]                  wr_addr,
   input  wire logic [rtu_fg_pkg::BYTE_W-1:0] wr_data,
   input  wire logic                           rd_en,
   input  wire logic [AW-1:0]                  rd_addr,
   output logic      [rtu_fg_pkg::BYTE_W-1:0] rd_data
);

   logic [rtu_fg_pkg::BYTE_W-1:0] mem [DEPTH];
   logic [rtu_fg_pkg::BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // hold read data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : rtu_fg_buf
`default_nettype wire

FILE: rtl/rtu_frame_gap_receiver_top.sv
`default_nettype none
// The response beat for an accepted request beat is registered and follows in the next cycle.
// Throughput: one request beat per cycle; a new beat is taken whenever the
//   response register is empty or drains in the same cycle.
// Reset (synchronous, active high): idle, length zero, frame_ready clear,
//   gap counter zero, gap_ticks back to 10. The frame buffer is not cleared.
// ----------------------------------------------------------------------------
// RTU frame gap receiver
// Collects received bytes into a frame buffer and closes the frame after a
// run of silent ticks; answers buffer reads and reports status per event.
// ----------------------------------------------------------------------------
module rtu_frame_gap_receiver_top #(
   parameter int BUF_DEPTH = rtu_fg_pkg::BUF_DEPTH_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   rtu_fg_req_if.sink   req_if,
   rtu_fg_rsp_if.source rsp_if,
   rtu_fg_csr_if.sink   csr_if
);

   localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
   localparam int CW = $clog2(BUF_DEPTH + 1);
   localparam int GW = rtu_fg_pkg::GAP_W;

   // receiver state, one-hot
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RECV = 2'b10
   } rx_state_type;

   rx_state_type  state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          ready_ff, ready_in;
   logic [GW-1:0] gap_ff, gap_in;
   logic [GW-1:0] gap_ticks_ff;
   logic          rsp_valid_ff;
   logic          rd_sel_ff, rd_sel_in;

   logic          accept;
   logic [CW-1:0] base;
   logic [GW-1:0] gap_inc;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic          rd_en;
   logic [rtu_fg_pkg::BYTE_W-1:0] rd_data;

   // Take a beat whenever the response slot is free or drains this cycle.
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   // The user must write the threshold register only while idle; this block does not enforce it and always takes it.
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ticks_ff <= rtu_fg_pkg::GAP_TICKS_RST;
      end else if (csr_if.valid && csr_if.ready) begin
         gap_ticks_ff <= csr_if.gap_ticks;
      end
   end

   // Next-state logic: all work for one event fits in this single pass.
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      ready_in  = ready_ff;
      gap_in    = gap_ff;
      rd_sel_in = rd_sel_ff;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      // a byte seen while idle restarts the frame at position zero
      base      = (state_ff == ST_IDLE) ? '0 : count_ff;
      wr_addr   = base[AW-1:0];
      // stop counting at the threshold; a count already above a lowered threshold holds
      gap_inc   = (gap_ff < gap_ticks_ff) ? gap_ff + GW'(1) : gap_ff;

      if (accept) begin
         rd_sel_in = 1'b0;
         case (req_if.req_type)
            rtu_fg_pkg::EV_BYTE: begin
               if (state_ff == ST_IDLE) begin
                  ready_in = 1'b0;
                  state_in = ST_RECV;
               end
               count_in = base;
               // drop bytes once the buffer is full, length holds at depth
               if (base < CW'(BUF_DEPTH)) begin
                  wr_en    = 1'b1;
                  count_in = base + CW'(1);
               end
               gap_in = '0;
            end
            rtu_fg_pkg::EV_TICK: begin
               gap_in = gap_inc;
               // close the frame once the line has been silent long enough
               if (state_ff == ST_RECV && gap_inc >= gap_ticks_ff) begin
                  ready_in = 1'b1;
                  state_in = ST_IDLE;
               end
            end
            rtu_fg_pkg::EV_CLEAR: begin
               ready_in = 1'b0;
               count_in = '0;
            end
            rtu_fg_pkg::EV_READ: begin
               // reads past the buffer return zero
               if (32'(req_if.read_index) < 32'(BUF_DEPTH)) begin
                  rd_en     = 1'b1;
                  rd_sel_in = 1'b1;
               end
            end
            default: begin
               rd_sel_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ready_ff     <= 1'b0;
         gap_ff       <= '0;
         rd_sel_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         ready_ff  <= ready_in;
         gap_ff    <= gap_in;
         rd_sel_ff <= rd_sel_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   rtu_fg_buf #(
      .DEPTH (BUF_DEPTH),
      .AW    (AW)
   ) u_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_if.rx_byte),
      .rd_en   (rd_en),
      .rd_addr (AW'(req_if.read_index)),
      .rd_data (rd_data)
   );

   // State only moves on an accepted beat, so while a response stalls the
   // status registers still show that beat's result.
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.frame_ready = ready_ff;
   assign rsp_if.frame_len   = rtu_fg_pkg::LEN_W'(count_ff);
   assign rsp_if.receiving   = (state_ff == ST_RECV);
   assign rsp_if.read_data   = rd_sel_ff ? rd_data : '0;

   // a finished frame and a frame in progress never coexist
   a_ready_not_recv: assert property (@(posedge clock) disable iff (reset)
      !(ready_ff && state_ff == ST_RECV))
      else $error("frame_ready set while receiving");

   // the stored length never passes the buffer depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(BUF_DEPTH))
      else $error("frame length beyond buffer depth");

   // a byte beat restarts the gap counter
   a_byte_gap: assert property (@(posedge clock) disable iff (reset)
      accept && req_if.req_type == rtu_fg_pkg::EV_BYTE |=> gap_ff == '0)
      else $error("gap counter not restarted by byte");

   // every accepted beat yields a response on the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("response missing after accepted beat");

endmodule : rtu_frame_gap_receiver_top
`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTU frame gap receiver testbench
// Drives byte, tick, clear and read events into the receiver, keeps a shadow
// copy of the frame buffer, length, gap counter and flags, and checks every
// status beat field by field. A short scripted sequence comes first, then
// gap threshold phases with random frame traffic and random stalls.
// ----------------------------------------------------------------------------
module testbench;

   localparam int DEPTH = rtu_fg_pkg::BUF_DEPTH_DEF;

   // one status beat: the receiver state after an event
   typedef struct packed {
      logic                              frame_ready;
      logic [rtu_fg_pkg::LEN_W-1:0]     frame_len;
      logic                              receiving;
      logic [rtu_fg_pkg::BYTE_W-1:0]    read_data;
   } frame_status_type;

   // one line of the scripted sequence; bytes count up over repeats
   typedef struct {
      rtu_fg_pkg::req_kind_type          kind;
      logic [rtu_fg_pkg::BYTE_W-1:0]    value;
      logic [rtu_fg_pkg::INDEX_W-1:0]   idx;
      int                                reps;
      bit                                typed;
      frame_status_type                  status;
   } script_row_type;

   localparam frame_status_type NO_STATUS = '0;

   logic clock;
   logic reset;

   rtu_fg_req_if req_ch ();
   rtu_fg_rsp_if rsp_ch ();
   rtu_fg_csr_if csr_ch ();

   rtu_frame_gap_receiver_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   // shadow receiver state
   logic [rtu_fg_pkg::BYTE_W-1:0] shadow_buf [DEPTH];
   logic [DEPTH-1:0]              written_map;
   logic [rtu_fg_pkg::LEN_W-1:0]  shadow_len;
   logic                          shadow_active;
   logic                          shadow_done;
   logic [rtu_fg_pkg::GAP_W-1:0]  silence_count;
   logic [rtu_fg_pkg::GAP_W-1:0]  gap_limit;

   frame_status_type pending_status [$];
   script_row_type   script [$];
   int               error_count;
   int               events_sent;
   bit               calm;         // no idling on either side while set

   always #5 clock = ~clock;

   // Give up long after the slowest legal run would have ended.
   initial begin
      #20_000_000;
      $display("testbench: done, errors");
      $finish;
   end

   // Apply one event to the shadow state and return the status it leaves.
   function automatic frame_status_type advance_receiver(
         rtu_fg_pkg::req_kind_type kind,
         logic [rtu_fg_pkg::BYTE_W-1:0] value,
         logic [rtu_fg_pkg::INDEX_W-1:0] idx);
      frame_status_type st;
      st.read_data = '0;
      case (kind)
         rtu_fg_pkg::EV_BYTE: begin
            // a byte while idle opens a fresh frame
            if (!shadow_active) begin
               shadow_len    = '0;
               shadow_done   = 1'b0;
               shadow_active = 1'b1;
            end
            // drop bytes once the buffer is full, but still restart the gap
            if (shadow_len < DEPTH) begin
               shadow_buf[shadow_len[rtu_fg_pkg::INDEX_W-1:0]]  = value;
               written_map[shadow_len[rtu_fg_pkg::INDEX_W-1:0]] = 1'b1;
               shadow_len++;
            end
            silence_count = '0;
         end
         rtu_fg_pkg::EV_TICK: begin
            // stop counting at the threshold; a count above a lowered one holds
            if (silence_count < gap_limit) silence_count++;
            if (shadow_active && silence_count >= gap_limit) begin
               shadow_done   = 1'b1;
               shadow_active = 1'b0;
            end
         end
         rtu_fg_pkg::EV_CLEAR: begin
            // the frame in progress, if any, goes on at position zero
            shadow_done = 1'b0;
            shadow_len  = '0;
         end
         default: begin
            if (idx < DEPTH) st.read_data = shadow_buf[idx];
         end
      endcase
      st.frame_ready = shadow_done;
      st.frame_len   = shadow_len;
      st.receiving   = shadow_active;
      return st;
   endfunction

   function automatic bit sender_idles();
      return !calm && ($urandom_range(0, 99) < 15);
   endfunction

   function automatic void add_row(rtu_fg_pkg::req_kind_type kind,
                                   logic [rtu_fg_pkg::BYTE_W-1:0] value,
                                   logic [rtu_fg_pkg::INDEX_W-1:0] idx, int reps,
                                   bit typed, frame_status_type status);
      script_row_type r;
      r.kind   = kind;
      r.value  = value;
      r.idx    = idx;
      r.reps   = reps;
      r.typed  = typed;
      r.status = status;
      script.push_back(r);
   endfunction

   // Present one event beat, hold it until taken, then log its status.
   task automatic send_event(rtu_fg_pkg::req_kind_type kind,
                             logic [rtu_fg_pkg::BYTE_W-1:0] value,
                             logic [rtu_fg_pkg::INDEX_W-1:0] idx, bit typed = 1'b0,
                             frame_status_type status = NO_STATUS);
      frame_status_type predicted;
      @(negedge clock);
      while (sender_idles()) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.req_type   <= kind;
      req_ch.rx_byte    <= value;
      req_ch.read_index <= idx;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predicted = advance_receiver(kind, value, idx);
      pending_status.push_back(typed ? status : predicted);
      events_sent++;
   endtask

   // Read only entries written since reset; fall back to a tick otherwise.
   task automatic send_read();
      logic [rtu_fg_pkg::INDEX_W-1:0] idx;
      if (written_map == '0) begin
         send_event(rtu_fg_pkg::EV_TICK, rtu_fg_pkg::BYTE_W'($urandom), '0);
      end else begin
         do idx = rtu_fg_pkg::INDEX_W'($urandom_range(0, DEPTH - 1));
         while (!written_map[idx]);
         send_event(rtu_fg_pkg::EV_READ, rtu_fg_pkg::BYTE_W'($urandom), idx);
      end
   endtask

   // Hold until every status beat is back and the pipeline has settled.
   task automatic drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Write the gap threshold; only called with the receiver drained.
   task automatic write_gap(logic [rtu_fg_pkg::GAP_W-1:0] value);
      drain();
      @(negedge clock);
      csr_ch.valid     <= 1'b1;
      csr_ch.gap_ticks <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      gap_limit = value;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // Send one event of the given kind with random payload.
   task automatic send_any(rtu_fg_pkg::req_kind_type kind);
      send_event(kind, rtu_fg_pkg::BYTE_W'($urandom), rtu_fg_pkg::INDEX_W'($urandom));
   endtask

   // Mostly whole frames: bytes, a few reads, a silent gap, then housekeeping.
   // The rest is single events of any kind.
   task automatic run_traffic(int count);
      int start;
      int nbytes;
      int nticks;
      start = events_sent;
      while (events_sent - start < count) begin
         // now and then hold off until the receiver has answered everything
         if ($urandom_range(0, 99) < 3) drain();
         if ($urandom_range(0, 99) < 80) begin
            nbytes = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70)
                                                  : $urandom_range(1, 12);
            for (int i = 0; i < nbytes; i++) begin
               send_any(rtu_fg_pkg::EV_BYTE);
               if ($urandom_range(0, 99) < 10) send_read();
               if ($urandom_range(0, 99) < 3) send_any(rtu_fg_pkg::EV_CLEAR);
            end
            // with a big threshold the frame stays open; otherwise mostly close it
            if (gap_limit > 40)
               nticks = $urandom_range(1, 40);
            else if ($urandom_range(0, 3) == 0)
               nticks = $urandom_range(0, gap_limit);
            else
               nticks = gap_limit + $urandom_range(0, 2);
            repeat (nticks) send_any(rtu_fg_pkg::EV_TICK);
            repeat ($urandom_range(0, 3)) send_read();
            if ($urandom_range(0, 1) == 0) send_any(rtu_fg_pkg::EV_CLEAR);
         end else begin
            case ($urandom_range(0, 3))
               0: send_any(rtu_fg_pkg::EV_BYTE);
               1: send_any(rtu_fg_pkg::EV_TICK);
               2: send_any(rtu_fg_pkg::EV_CLEAR);
               default: send_read();
            endcase
         end
      end
   endtask

   // Response side: stall at random, except during a calm stretch.
   always @(negedge clock) begin
      rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 15);
   end

   // Check each status beat against the oldest expectation.
   always @(posedge clock) begin
      frame_status_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_status.size() == 0) begin
            $error("status beat with nothing expected");
            error_count++;
         end else begin
            want = pending_status.pop_front();
            if (rsp_ch.frame_ready !== want.frame_ready) begin
               $error("frame_ready: expected %0d, got %0d", want.frame_ready,
                      rsp_ch.frame_ready);
               error_count++;
            end
            if (rsp_ch.frame_len !== want.frame_len) begin
               $error("frame_len: expected %0d, got %0d", want.frame_len,
                      rsp_ch.frame_len);
               error_count++;
            end
            if (rsp_ch.receiving !== want.receiving) begin
               $error("receiving: expected %0d, got %0d", want.receiving,
                      rsp_ch.receiving);
               error_count++;
            end
            if (rsp_ch.read_data !== want.read_data) begin
               $error("read_data: expected 0x%02h, got 0x%02h", want.read_data,
                      rsp_ch.read_data);
               error_count++;
            end
         end
      end
   end

   initial begin
      clock             = 1'b0;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.req_type   = rtu_fg_pkg::EV_BYTE;
      req_ch.rx_byte    = '0;
      req_ch.read_index = '0;
      rsp_ch.ready      = 1'b0;
      csr_ch.valid      = 1'b0;
      csr_ch.gap_ticks  = '0;
      error_count       = 0;
      events_sent       = 0;
      calm              = 1'b0;
      written_map       = '0;
      shadow_len        = '0;
      shadow_active     = 1'b0;
      shadow_done       = 1'b0;
      silence_count     = '0;
      gap_limit         = rtu_fg_pkg::GAP_TICKS_RST;
      for (int i = 0; i < DEPTH; i++) shadow_buf[i] = '0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Scripted sequence at the reset threshold of ten ticks.
      // Ticks and a clear right out of reset leave everything at zero.
      add_row(rtu_fg_pkg::EV_TICK,  8'h00, 6'd0,  1, 1'b1, {1'b0, 7'd0,  1'b0, 8'h00});
      add_row(rtu_fg_pkg::EV_CLEAR, 8'h00, 6'd0,  1, 1'b1, {1'b0, 7'd0,  1'b0, 8'h00});
      // Open a frame with the two byte extremes and read them back.
      add_row(rtu_fg_pkg::EV_BYTE,  8'h00, 6'd0,  1, 1'b1, {1'b0, 7'd1,  1'b1, 8'h00});
      add_row(rtu_fg_pkg::EV_BYTE,  8'hFF, 6'd0,  1, 1'b1, {1'b0, 7'd2,  1'b1, 8'h00});
      add_row(rtu_fg_pkg::EV_READ,  8'h00, 6'd0,  1, 1'b1, {1'b0, 7'd2,  1'b1, 8'h00});
      add_row(rtu_fg_pkg::EV_READ,  8'h00, 6'd1,  1, 1'b1, {1'b0, 7'd2,  1'b1, 8'hFF});
      // One tick short of the gap, then the closing tick, then a saturated one.
      add_row(rtu_fg_pkg::EV_TICK,  8'h00, 6'd0,  9, 1'b1, {1'b0, 7'd2,  1'b1, 8'h00});
      add_row(rtu_fg_pkg::EV_TICK,  8'h00, 6'd0,  1, 1'b1, {1'b1, 7'd2,  1'b0, 8'h00});
      add_row(rtu_fg_pkg::EV_TICK,  8'h00, 6'd0,  1, 1'b1, {1'b1, 7'd2,  1'b0, 8'h00});
      add_row(rtu_fg_pkg::EV_READ,  8'h00, 6'd1,  1, 1'b1, {1'b1, 7'd2,  1'b0, 8'hFF});
      add_row(rtu_fg_pkg::EV_CLEAR, 8'h00, 6'd0,  1, 1'b1, {1'b0, 7'd0,  1'b0, 8'h00});
      // Clear mid-frame: still receiving, next byte lands at position zero.
      add_row(rtu_fg_pkg::EV_BYTE,  8'h5A, 6'd0,  1, 1'b1, {1'b0, 7'd1,  1'b1, 8'h00});
      add_row(rtu_fg_pkg::EV_CLEAR, 8'h00, 6'd0,  1, 1'b1, {1'b0, 7'd0,  1'b1, 8'h00});
      add_row(rtu_fg_pkg::EV_BYTE,  8'hA5, 6'd0,  1, 1'b1, {1'b0, 7'd1,  1'b1, 8'h00});
      add_row(rtu_fg_pkg::EV_READ,  8'h00, 6'd0,  1, 1'b1, {1'b0, 7'd1,  1'b1, 8'hA5});
      // Overrun the buffer: the length saturates and extra bytes drop.
      add_row(rtu_fg_pkg::EV_BYTE,  8'h01, 6'd0, 66, 1'b1, {1'b0, 7'd64, 1'b1, 8'h00});
      add_row(rtu_fg_pkg::EV_READ,  8'h00, 6'd63, 1, 1'b0, NO_STATUS);
      add_row(rtu_fg_pkg::EV_READ,  8'h00, 6'd42, 1, 1'b0, NO_STATUS);
      add_row(rtu_fg_pkg::EV_READ,  8'h00, 6'd21, 1, 1'b0, NO_STATUS);
      add_row(rtu_fg_pkg::EV_TICK,  8'h00, 6'd0, 10, 1'b1, {1'b1, 7'd64, 1'b0, 8'h00});
      // A byte after a finished frame starts over.
      add_row(rtu_fg_pkg::EV_BYTE,  8'h80, 6'd0,  1, 1'b1, {1'b0, 7'd1,  1'b1, 8'h00});
      add_row(rtu_fg_pkg::EV_TICK,  8'h00, 6'd0,  3, 1'b0, NO_STATUS);

      // Only the last repeat of a row carries the typed-in status.
      foreach (script[r]) begin
         for (int i = 0; i < script[r].reps; i++) begin
            send_event(script[r].kind,
                       (script[r].kind == rtu_fg_pkg::EV_BYTE)
                          ? script[r].value + rtu_fg_pkg::BYTE_W'(i)
                          : script[r].value,
                       script[r].idx,
                       script[r].typed && (i == script[r].reps - 1),
                       script[r].status);
         end
      end

      // Smallest threshold: every tick closes an open frame.
      write_gap(16'd1);
      run_traffic(150);

      // Largest threshold: frames stay open; leave one open with twenty
      // silent ticks behind it.
      write_gap(16'hFFFF);
      run_traffic(100);
      send_any(rtu_fg_pkg::EV_BYTE);
      repeat (20) send_any(rtu_fg_pkg::EV_TICK);

      // Drop the threshold below the running count, with no stalls at all.
      write_gap(16'd5);
      calm = 1'b1;
      run_traffic(150);
      calm = 1'b0;

      write_gap(rtu_fg_pkg::GAP_W'($urandom_range(2, 40)));
      run_traffic(150);
      write_gap(rtu_fg_pkg::GAP_W'($urandom_range(41, 65534)));
      run_traffic(100);
      write_gap(16'd3);
      run_traffic(100);

      drain();
      if (error_count == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule : testbench

FILE: sim.f
rtl/rtu_fg_pkg.sv
rtl/rtu_fg_if.sv
rtl/rtu_fg_buf.sv
rtl/rtu_frame_gap_receiver_top.sv
dv/testbench.sv
